// ----- design/s5hp_pkg.sv -----
// shared constants, codes and result types of the socks5 handshake parser
// no dependencies; every other file refers to this package by scoped names
package s5hp_pkg;

   // default sizes
   localparam int MAX_CRED_LEN = 16;
   localparam int RSP_DEPTH    = 4;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int LEN_W       = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_USER_LEN  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PASS_LEN  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_USER_LOW  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_USER_HIGH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PASS_LOW  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PASS_HIGH = 3'd5;

   // result kinds
   localparam logic [1:0] KIND_REPLY = 2'd0;
   localparam logic [1:0] KIND_ADDR  = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_DROP  = 2'd3;

   // request status codes
   localparam logic [1:0] STAT_GO         = 2'd0;
   localparam logic [1:0] STAT_CMD_UNSUP  = 2'd1;
   localparam logic [1:0] STAT_ATYP_UNSUP = 2'd2;

   // protocol bytes
   localparam logic [7:0] SOCKS_VER       = 8'h05;
   localparam logic [7:0] AUTH_VER        = 8'h01;
   localparam logic [7:0] METH_USERPASS   = 8'h02;
   localparam logic [7:0] METH_NONE       = 8'hFF;
   localparam logic [7:0] AUTH_OK         = 8'h00;
   localparam logic [7:0] AUTH_FAIL       = 8'h01;
   localparam logic [7:0] CMD_CONN        = 8'h01;
   localparam logic [7:0] CMD_UDP         = 8'h03;
   localparam logic [7:0] ATYP_IPV4       = 8'h01;
   localparam logic [7:0] ATYP_DOMAIN     = 8'h03;
   localparam logic [7:0] ATYP_IPV6       = 8'h04;
   localparam logic [7:0] IPV4_REST       = 8'd3;
   localparam logic [7:0] IPV6_REST       = 8'd15;
   localparam logic [7:0] REQ_HDR_LAST    = 8'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  value;
      logic        last_of_run;
      logic [1:0]  command;
      logic [7:0]  address_type;
      logic [15:0] dest_port;
      logic [1:0]  request_status;
   } rsp_item_type;

   // up to two words produced by one input word
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_push_type;

endpackage

// ----- design/s5hp_if.sv -----
// channel interfaces of the socks5 handshake parser: input, result and configuration
// only the configuration widths come from s5hp_pkg
interface s5hp_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;

   modport source (output valid, func, data_byte, input ready);
   modport sink   (input valid, func, data_byte, output ready);
endinterface

interface s5hp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  value;
   logic        last_of_run;
   logic [1:0]  command;
   logic [7:0]  address_type;
   logic [15:0] dest_port;
   logic [1:0]  request_status;

   modport source (output valid, kind, value, last_of_run, command, address_type,
                   dest_port, request_status, input ready);
   modport sink   (input valid, kind, value, last_of_run, command, address_type,
                   dest_port, request_status, output ready);
endinterface

interface s5hp_csr_if;
   logic                           valid;
   logic                           ready;
   logic [s5hp_pkg::CSR_INDEX_W-1:0] index;
   logic [s5hp_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/s5hp_parser.sv -----
// handshake phase tracker: consumes one registered input word, updates the
// parse state and produces up to two result words; uses s5hp_pkg
module s5hp_parser #(
   parameter int MaxCredLen = s5hp_pkg::MAX_CRED_LEN
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic                         func,
   input  logic [7:0]                   data_byte,
   input  logic [s5hp_pkg::LEN_W-1:0]   user_len,
   input  logic [s5hp_pkg::LEN_W-1:0]   pass_len,
   input  logic [7:0]                   user_bytes [MaxCredLen],
   input  logic [7:0]                   pass_bytes [MaxCredLen],
   output s5hp_pkg::rsp_push_type       push
);

   // phase codes
   localparam logic [3:0] PH_GREET_HDR  = 4'd0;
   localparam logic [3:0] PH_GREET_METH = 4'd1;
   localparam logic [3:0] PH_AUTH_HDR   = 4'd2;
   localparam logic [3:0] PH_AUTH_USER  = 4'd3;
   localparam logic [3:0] PH_AUTH_PLEN  = 4'd4;
   localparam logic [3:0] PH_AUTH_PASS  = 4'd5;
   localparam logic [3:0] PH_REQ_HDR    = 4'd6;
   localparam logic [3:0] PH_REQ_ADDR   = 4'd7;
   localparam logic [3:0] PH_REQ_PORT   = 4'd8;
   localparam logic [3:0] PH_MUTE       = 4'd9;

   logic [3:0] phase_ff, phase_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] rem_ff, rem_in;
   logic       meth_ff, meth_in;
   logic       match_ff, match_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] atyp_ff, atyp_in;
   logic [7:0] porth_ff, porth_in;

   logic       user_hit;
   logic       pass_hit;
   logic [7:0] rem_dec;
   s5hp_pkg::rsp_push_type push_in;

   function automatic s5hp_pkg::rsp_item_type mk_item(
      input logic [1:0]  kind,
      input logic [7:0]  value,
      input logic        last,
      input logic [1:0]  command,
      input logic [7:0]  atyp,
      input logic [15:0] port,
      input logic [1:0]  status
   );
      s5hp_pkg::rsp_item_type it;
      it.kind           = kind;
      it.value          = value;
      it.last_of_run    = last;
      it.command        = command;
      it.address_type   = atyp;
      it.dest_port      = port;
      it.request_status = status;
      return it;
   endfunction

   // credential byte compare at the current position, never beyond the stored bytes
   always_comb begin
      user_hit = 1'b0;
      pass_hit = 1'b0;
      for (int i = 0; i < MaxCredLen; i++) begin
         if (pos_ff == 8'(i) && user_bytes[i] == data_byte) user_hit = 1'b1;
         if (pos_ff == 8'(i) && pass_bytes[i] == data_byte) pass_hit = 1'b1;
      end
   end

   assign rem_dec = rem_ff - 8'd1;

   // phase logic
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      rem_in   = rem_ff;
      meth_in  = meth_ff;
      match_in = match_ff;
      cmd_in   = cmd_ff;
      atyp_in  = atyp_ff;
      porth_in = porth_ff;
      push_in  = '0;

      if (fire && func) begin
         phase_in = PH_GREET_HDR;
         pos_in   = 8'd0;
         rem_in   = 8'd2;
         meth_in  = 1'b0;
         match_in = 1'b1;
         cmd_in   = 8'd0;
         atyp_in  = 8'd0;
         porth_in = 8'd0;
      end else if (fire) begin
         unique case (phase_ff)
            PH_GREET_HDR: begin
               if (pos_ff == 8'd0) begin
                  porth_in = data_byte;
                  pos_in   = 8'd1;
               end else if (porth_ff != s5hp_pkg::SOCKS_VER || data_byte == 8'd0) begin
                  phase_in      = PH_MUTE;
                  push_in.count = 2'd1;
                  push_in.item0 = mk_item(s5hp_pkg::KIND_DROP, 8'd0, 1'b1, 2'd0, 8'd0,
                                          16'd0, 2'd0);
               end else begin
                  phase_in = PH_GREET_METH;
                  meth_in  = 1'b0;
                  rem_in   = data_byte;
                  pos_in   = 8'd0;
               end
            end
            PH_GREET_METH: begin
               meth_in = meth_ff | (data_byte == s5hp_pkg::METH_USERPASS);
               rem_in  = rem_dec;
               if (rem_dec == 8'd0) begin
                  push_in.count = 2'd2;
                  push_in.item0 = mk_item(s5hp_pkg::KIND_REPLY, s5hp_pkg::SOCKS_VER, 1'b0,
                                          2'd0, 8'd0, 16'd0, 2'd0);
                  if (meth_in) begin
                     push_in.item1 = mk_item(s5hp_pkg::KIND_REPLY, s5hp_pkg::METH_USERPASS,
                                             1'b1, 2'd0, 8'd0, 16'd0, 2'd0);
                     phase_in = PH_AUTH_HDR;
                     pos_in   = 8'd0;
                     rem_in   = 8'd2;
                  end else begin
                     push_in.item1 = mk_item(s5hp_pkg::KIND_REPLY, s5hp_pkg::METH_NONE,
                                             1'b1, 2'd0, 8'd0, 16'd0, 2'd0);
                     phase_in = PH_MUTE;
                  end
               end
            end
            PH_AUTH_HDR: begin
               if (pos_ff == 8'd0) begin
                  porth_in = data_byte;
                  pos_in   = 8'd1;
               end else if (porth_ff != s5hp_pkg::AUTH_VER || data_byte == 8'd0) begin
                  phase_in      = PH_MUTE;
                  push_in.count = 2'd1;
                  push_in.item0 = mk_item(s5hp_pkg::KIND_DROP, 8'd0, 1'b1, 2'd0, 8'd0,
                                          16'd0, 2'd0);
               end else begin
                  match_in = (data_byte == {3'd0, user_len});
                  phase_in = PH_AUTH_USER;
                  rem_in   = data_byte;
                  pos_in   = 8'd0;
               end
            end
            PH_AUTH_USER: begin
               if (!user_hit) match_in = 1'b0;
               pos_in = pos_ff + 8'd1;
               rem_in = rem_dec;
               if (rem_dec == 8'd0) phase_in = PH_AUTH_PLEN;
            end
            PH_AUTH_PLEN: begin
               if (data_byte == 8'd0) begin
                  phase_in      = PH_MUTE;
                  push_in.count = 2'd1;
                  push_in.item0 = mk_item(s5hp_pkg::KIND_DROP, 8'd0, 1'b1, 2'd0, 8'd0,
                                          16'd0, 2'd0);
               end else begin
                  if (data_byte != {3'd0, pass_len}) match_in = 1'b0;
                  phase_in = PH_AUTH_PASS;
                  rem_in   = data_byte;
                  pos_in   = 8'd0;
               end
            end
            PH_AUTH_PASS: begin
               match_in = match_ff & pass_hit;
               pos_in   = pos_ff + 8'd1;
               rem_in   = rem_dec;
               if (rem_dec == 8'd0) begin
                  push_in.count = 2'd2;
                  push_in.item0 = mk_item(s5hp_pkg::KIND_REPLY, s5hp_pkg::AUTH_VER, 1'b0,
                                          2'd0, 8'd0, 16'd0, 2'd0);
                  if (match_in) begin
                     push_in.item1 = mk_item(s5hp_pkg::KIND_REPLY, s5hp_pkg::AUTH_OK, 1'b1,
                                             2'd0, 8'd0, 16'd0, 2'd0);
                     phase_in = PH_REQ_HDR;
                     pos_in   = 8'd0;
                     rem_in   = 8'd5;
                  end else begin
                     push_in.item1 = mk_item(s5hp_pkg::KIND_REPLY, s5hp_pkg::AUTH_FAIL, 1'b1,
                                             2'd0, 8'd0, 16'd0, 2'd0);
                     phase_in = PH_MUTE;
                  end
               end
            end
            PH_REQ_HDR: begin
               if (pos_ff < s5hp_pkg::REQ_HDR_LAST) begin
                  // version, command, reserved, address type
                  if (pos_ff == 8'd0) porth_in = data_byte;
                  if (pos_ff == 8'd1) cmd_in = data_byte;
                  if (pos_ff == 8'd3) atyp_in = data_byte;
                  pos_in = pos_ff + 8'd1;
               end else if (porth_ff != s5hp_pkg::SOCKS_VER || cmd_ff < s5hp_pkg::CMD_CONN
                            || cmd_ff > s5hp_pkg::CMD_UDP) begin
                  phase_in      = PH_MUTE;
                  push_in.count = 2'd1;
                  push_in.item0 = mk_item(s5hp_pkg::KIND_DROP, 8'd0, 1'b1, 2'd0, 8'd0,
                                          16'd0, 2'd0);
               end else if (atyp_ff == s5hp_pkg::ATYP_IPV4 || atyp_ff == s5hp_pkg::ATYP_DOMAIN
                            || atyp_ff == s5hp_pkg::ATYP_IPV6) begin
                  // first address byte (domain length octet for names)
                  if (atyp_ff == s5hp_pkg::ATYP_IPV4) rem_in = s5hp_pkg::IPV4_REST;
                  else if (atyp_ff == s5hp_pkg::ATYP_IPV6) rem_in = s5hp_pkg::IPV6_REST;
                  else rem_in = data_byte;
                  phase_in      = (rem_in == 8'd0) ? PH_REQ_PORT : PH_REQ_ADDR;
                  pos_in        = 8'd0;
                  push_in.count = 2'd1;
                  push_in.item0 = mk_item(s5hp_pkg::KIND_ADDR, data_byte, 1'b1, 2'd0, 8'd0,
                                          16'd0, 2'd0);
               end else begin
                  phase_in      = PH_MUTE;
                  push_in.count = 2'd1;
                  push_in.item0 = mk_item(s5hp_pkg::KIND_DONE, 8'd0, 1'b1, cmd_ff[1:0],
                                          atyp_ff, 16'd0, s5hp_pkg::STAT_ATYP_UNSUP);
               end
            end
            PH_REQ_ADDR: begin
               rem_in = rem_dec;
               if (rem_dec == 8'd0) begin
                  phase_in = PH_REQ_PORT;
                  pos_in   = 8'd0;
               end
               push_in.count = 2'd1;
               push_in.item0 = mk_item(s5hp_pkg::KIND_ADDR, data_byte, 1'b1, 2'd0, 8'd0,
                                       16'd0, 2'd0);
            end
            PH_REQ_PORT: begin
               if (pos_ff == 8'd0) begin
                  porth_in = data_byte;
                  pos_in   = 8'd1;
               end else begin
                  phase_in      = PH_MUTE;
                  push_in.count = 2'd1;
                  push_in.item0 = mk_item(s5hp_pkg::KIND_DONE, 8'd0, 1'b1, cmd_ff[1:0],
                                          atyp_ff, {porth_ff, data_byte},
                                          (cmd_ff == s5hp_pkg::CMD_CONN) ?
                                          s5hp_pkg::STAT_GO : s5hp_pkg::STAT_CMD_UNSUP);
               end
            end
            default: begin
               // mute: swallow bytes until a new session
            end
         endcase
      end
   end

   assign push = push_in;

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_GREET_HDR;
         pos_ff   <= 8'd0;
         rem_ff   <= 8'd2;
         meth_ff  <= 1'b0;
         match_ff <= 1'b1;
         cmd_ff   <= 8'd0;
         atyp_ff  <= 8'd0;
         porth_ff <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         rem_ff   <= rem_in;
         meth_ff  <= meth_in;
         match_ff <= match_in;
         cmd_ff   <= cmd_in;
         atyp_ff  <= atyp_in;
         porth_ff <= porth_in;
      end
   end

   // a muted session never produces results
   a_mute_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MUTE && !func) |-> push_in.count == 2'd0)
      else $error("result produced while muted");

endmodule

// ----- design/s5hp_rsp_queue.sv -----
// small result queue: takes up to two words per cycle, releases one per cycle while popped
// uses s5hp_pkg result types
module s5hp_rsp_queue #(
   parameter int Depth = s5hp_pkg::RSP_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  s5hp_pkg::rsp_push_type push,
   input  logic                   pop,
   output s5hp_pkg::rsp_item_type head,
   output logic                   not_empty,
   output logic                   room
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   s5hp_pkg::rsp_item_type entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, wr_next;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   // pointer and fill level
   always_comb begin
      wr_next = next_ptr(wr_ptr_ff);
      case (push.count)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = next_ptr(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push.count) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.item0;
      if (push.count == 2'd2) entry_ff[wr_next] <= push.item1;
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign room      = (count_ff <= CntW'(Depth - 2));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> count_ff <= CntW'(Depth - 2))
      else $error("result queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("result queue underflow");

   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> (!push.item0.last_of_run && push.item1.last_of_run))
      else $error("reply pair marks the wrong word as last");

endmodule

// ----- design/socks5_handshake_parser.sv -----
// top level of the socks5 handshake parser: input register, credential registers,
// parser and result queue; uses s5hp_pkg, s5hp_if, s5hp_parser, s5hp_rsp_queue
//
// One client word is taken per cycle while the input register is empty or can pass
// its word on. A word is held in an input register; the parser handles it once the
// result queue has room and puts its results (one word, or two for the greeting and
// login replies) into a small result queue, whose registered head is what appears.
// The queue drains one word per cycle while the result side is ready; the input
// stalls only while the queue holds more than RspDepth-2 words, as under back-pressure
// on the result side. Configuration writes are taken every cycle and cleared by reset.
module socks5_handshake_parser #(
   parameter int MaxCredLen = s5hp_pkg::MAX_CRED_LEN,
   parameter int RspDepth   = s5hp_pkg::RSP_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   s5hp_req_if.sink          req_bus,
   s5hp_rsp_if.source        rsp_bus,
   s5hp_csr_if.sink          csr_bus
);

   logic       in_valid_ff;
   logic       in_func_ff;
   logic [7:0] in_byte_ff;
   logic       req_fire;
   logic       fire;
   logic       room;
   logic       csr_fire;

   logic [s5hp_pkg::LEN_W-1:0] user_len_ff;
   logic [s5hp_pkg::LEN_W-1:0] pass_len_ff;
   logic [7:0] user_byte_ff [MaxCredLen];
   logic [7:0] pass_byte_ff [MaxCredLen];

   s5hp_pkg::rsp_push_type push;
   s5hp_pkg::rsp_item_type head;
   logic                   not_empty;

   // input register
   assign fire          = in_valid_ff && room;
   assign req_bus.ready = !in_valid_ff || room;
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_func_ff <= req_bus.func;
         in_byte_ff <= req_bus.data_byte;
      end
   end

   // credential lengths
   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         user_len_ff <= '0;
         pass_len_ff <= '0;
      end else if (csr_fire) begin
         if (csr_bus.index == s5hp_pkg::CSR_USER_LEN)
            user_len_ff <= csr_bus.data[s5hp_pkg::LEN_W-1:0];
         if (csr_bus.index == s5hp_pkg::CSR_PASS_LEN)
            pass_len_ff <= csr_bus.data[s5hp_pkg::LEN_W-1:0];
      end
   end

   // credential bytes, eight to a configuration word
   for (genvar i = 0; i < MaxCredLen; i++) begin : g_cred
      localparam logic [s5hp_pkg::CSR_INDEX_W-1:0] UserIdx =
         (i < 8) ? s5hp_pkg::CSR_USER_LOW : s5hp_pkg::CSR_USER_HIGH;
      localparam logic [s5hp_pkg::CSR_INDEX_W-1:0] PassIdx =
         (i < 8) ? s5hp_pkg::CSR_PASS_LOW : s5hp_pkg::CSR_PASS_HIGH;
      localparam int Shift = 8 * (i % 8);

      always_ff @(posedge clock) begin
         if (reset) begin
            user_byte_ff[i] <= '0;
            pass_byte_ff[i] <= '0;
         end else if (csr_fire) begin
            if (csr_bus.index == UserIdx) user_byte_ff[i] <= csr_bus.data[Shift +: 8];
            if (csr_bus.index == PassIdx) pass_byte_ff[i] <= csr_bus.data[Shift +: 8];
         end
      end
   end

   s5hp_parser #(
      .MaxCredLen (MaxCredLen)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .func       (in_func_ff),
      .data_byte  (in_byte_ff),
      .user_len   (user_len_ff),
      .pass_len   (pass_len_ff),
      .user_bytes (user_byte_ff),
      .pass_bytes (pass_byte_ff),
      .push       (push)
   );

   s5hp_rsp_queue #(
      .Depth (RspDepth)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_bus.valid && rsp_bus.ready),
      .head      (head),
      .not_empty (not_empty),
      .room      (room)
   );

   // result channel
   assign rsp_bus.valid          = not_empty;
   assign rsp_bus.kind           = head.kind;
   assign rsp_bus.value          = head.value;
   assign rsp_bus.last_of_run    = head.last_of_run;
   assign rsp_bus.command        = head.command;
   assign rsp_bus.address_type   = head.address_type;
   assign rsp_bus.dest_port      = head.dest_port;
   assign rsp_bus.request_status = head.request_status;

   // a stalled input word stays in the register until the parser takes it
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !room) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_func_ff)))
      else $error("input word lost while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_bus.ready)
      else $error("input not ready with an empty input register");

endmodule
